FILE: src/pft_pkg.sv
// Shared types and constants for the planar frame transform unit.
// Holds the request and response payloads, the CORDIC stage records and the arctangent table.
// No dependencies.
package pft_pkg;

	localparam int COORD_W        = 32;
	localparam int ANGLE_BITS     = 16;
	localparam int PHASE_BITS     = 32;
	localparam int TRIG_W         = 32;
	localparam int TRIG_FRAC      = 30;
	localparam int CORDIC_STAGES  = 24;
	localparam int ITER_PER_STAGE = 2;
	localparam int DIFF_W         = COORD_W + 1;
	localparam int PROD_W         = DIFF_W + TRIG_W;
	localparam int SUM_W          = PROD_W + 1;
	localparam int RND_W          = SUM_W - TRIG_FRAC;
	localparam int FIN_W          = RND_W + 1;

	localparam logic signed [TRIG_W-1:0] GAIN_INV = 32'sd652032874;

	// atan(2^-i) in units of 2^-32 of a full turn.
	localparam logic signed [TRIG_W-1:0] ATAN_TURN [CORDIC_STAGES] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
		32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
		32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
		32'sd652,       32'sd326,       32'sd163,       32'sd81
	};

	typedef enum logic {
		CMD_W2L = 1'b0,
		CMD_L2W = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

	typedef struct packed {
		cmd_t                       cmd;
		logic signed [COORD_W-1:0]  pos_x;
		logic signed [COORD_W-1:0]  pos_y;
		logic signed [COORD_W-1:0]  origin_x;
		logic signed [COORD_W-1:0]  origin_y;
		logic [ANGLE_BITS-1:0]      angle;
	} pft_req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0]  out_x;
		logic signed [COORD_W-1:0]  out_y;
	} pft_rsp_t;

	// CORDIC stage record: rotation state plus the operands that ride along.
	typedef struct packed {
		cmd_t                       cmd;
		quad_t                      quad;
		logic signed [DIFF_W-1:0]   ax;
		logic signed [DIFF_W-1:0]   ay;
		logic signed [COORD_W-1:0]  ox;
		logic signed [COORD_W-1:0]  oy;
		logic signed [TRIG_W-1:0]   x;
		logic signed [TRIG_W-1:0]   y;
		logic signed [TRIG_W-1:0]   z;
	} cor_t;

	typedef struct packed {
		cmd_t                       cmd;
		logic signed [DIFF_W-1:0]   ax;
		logic signed [DIFF_W-1:0]   ay;
		logic signed [COORD_W-1:0]  ox;
		logic signed [COORD_W-1:0]  oy;
		logic signed [TRIG_W-1:0]   c;
		logic signed [TRIG_W-1:0]   s;
	} trig_t;

	typedef struct packed {
		cmd_t                       cmd;
		logic signed [COORD_W-1:0]  ox;
		logic signed [COORD_W-1:0]  oy;
		logic signed [PROD_W-1:0]   p_xc;
		logic signed [PROD_W-1:0]   p_ys;
		logic signed [PROD_W-1:0]   p_yc;
		logic signed [PROD_W-1:0]   p_xs;
	} prod_t;

	typedef struct packed {
		cmd_t                       cmd;
		logic signed [COORD_W-1:0]  ox;
		logic signed [COORD_W-1:0]  oy;
		logic signed [RND_W-1:0]    rx;
		logic signed [RND_W-1:0]    ry;
	} rnd_t;

endpackage

FILE: src/planar_frame_transform_unit.sv
// Top level of the planar frame transform: pipelined CORDIC rotator with origin offset.
// Depends on pft_pkg for payload types, stage records and the arctangent table.
//
// Usage: a request on req (req_valid/req_ready) carries a point, a frame origin, an angle
// as a 16-bit fraction of a full turn, and a direction. World to local subtracts the
// origin and rotates by minus the angle; local to world rotates by the angle and adds
// the origin. Each request yields exactly one response on rsp (rsp_valid/rsp_ready)
// with both coordinates rounded and saturated to the signed 32-bit range.
//
// The pipe is 17 register stages deep: one input stage, twelve CORDIC stages of two
// rotations each, then quadrant mapping, multiply, product sum with rounding, and origin
// add with saturation. Throughput is one request per cycle while the receiver keeps
// taking responses, set by the fully pipelined CORDIC chain and the single multiply stage.
//
// Every stage has its own valid bit and loads whenever it is empty or its successor
// loads, so a stalled receiver only freezes the occupied stages behind the output;
// empty slots keep filling and req_ready stays high until the whole pipe is full.
// Reset clears all valid bits, so req_ready is high as soon as reset is released.
module planar_frame_transform_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  pft_pkg::pft_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output pft_pkg::pft_rsp_t rsp
);
	import pft_pkg::*;

	// Stage layout: 0 input, 1..COR_STG CORDIC, then trig, product, round, result.
	localparam int COR_STG = CORDIC_STAGES / ITER_PER_STAGE;
	localparam int TRG_IDX = COR_STG + 1;
	localparam int PRD_IDX = COR_STG + 2;
	localparam int RND_IDX = COR_STG + 3;
	localparam int RSP_IDX = COR_STG + 4;
	localparam int NST     = COR_STG + 5;

	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (TRIG_FRAC - 1);
	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// One register stage worth of CORDIC rotations, with floor right shifts.
	function automatic cor_t cor_step(cor_t a, int base);
		cor_t r;
		logic signed [TRIG_W-1:0] xs;
		logic signed [TRIG_W-1:0] ys;
		int i;
		r = a;
		for (int j = 0; j < ITER_PER_STAGE; j++) begin
			i  = base + j;
			xs = r.x >>> i;
			ys = r.y >>> i;
			if (!r.z[TRIG_W-1]) begin
				r.x = r.x - ys;
				r.y = r.y + xs;
				r.z = r.z - ATAN_TURN[i];
			end else begin
				r.x = r.x + ys;
				r.y = r.y - xs;
				r.z = r.z + ATAN_TURN[i];
			end
		end
		return r;
	endfunction

	logic [NST-1:0] vld_s;
	logic [NST-1:0] en;

	cor_t     cor_s [COR_STG+1];
	trig_t    trg_s;
	prod_t    prd_s;
	rnd_t     rnd_s;
	pft_rsp_t rsp_s;

	// A stage loads when it is empty or when the stage after it loads.
	assign en[NST-1] = ~vld_s[NST-1] | rsp_ready;
	for (genvar k = 0; k < NST - 1; k++) begin : g_en
		assign en[k] = ~vld_s[k] | en[k+1];
	end

	assign req_ready = en[0];
	assign rsp_valid = vld_s[RSP_IDX];
	assign rsp       = rsp_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= req_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Input stage: form the rotation operands and the starting CORDIC vector.
	logic [PHASE_BITS-1:0]    phase;
	logic signed [DIFF_W-1:0] px_w, py_w, ox_w, oy_w;
	cor_t                     cor_in;

	always_comb begin
		phase = {req.angle, {(PHASE_BITS-ANGLE_BITS){1'b0}}};
		px_w  = {req.pos_x[COORD_W-1], req.pos_x};
		py_w  = {req.pos_y[COORD_W-1], req.pos_y};
		ox_w  = {req.origin_x[COORD_W-1], req.origin_x};
		oy_w  = {req.origin_y[COORD_W-1], req.origin_y};
		cor_in.cmd  = req.cmd;
		cor_in.quad = quad_t'(phase[PHASE_BITS-1 -: 2]);
		cor_in.ax   = (req.cmd == CMD_W2L) ? px_w - ox_w : px_w;
		cor_in.ay   = (req.cmd == CMD_W2L) ? py_w - oy_w : py_w;
		cor_in.ox   = req.origin_x;
		cor_in.oy   = req.origin_y;
		cor_in.x    = GAIN_INV;
		cor_in.y    = '0;
		cor_in.z    = {2'b00, phase[PHASE_BITS-3:0]};
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cor_s[0] <= cor_in;
		end
	end

	for (genvar k = 0; k < COR_STG; k++) begin : g_cor
		always_ff @(posedge clk) begin
			if (en[k+1]) begin
				cor_s[k+1] <= cor_step(cor_s[k], k * ITER_PER_STAGE);
			end
		end
	end

	// Map the first-quadrant rotation onto the full circle.
	trig_t trg_d;
	always_comb begin
		trg_d.cmd = cor_s[COR_STG].cmd;
		trg_d.ax  = cor_s[COR_STG].ax;
		trg_d.ay  = cor_s[COR_STG].ay;
		trg_d.ox  = cor_s[COR_STG].ox;
		trg_d.oy  = cor_s[COR_STG].oy;
		case (cor_s[COR_STG].quad)
			QUAD_I: begin
				trg_d.c = cor_s[COR_STG].x;
				trg_d.s = cor_s[COR_STG].y;
			end
			QUAD_II: begin
				trg_d.c = -cor_s[COR_STG].y;
				trg_d.s = cor_s[COR_STG].x;
			end
			QUAD_III: begin
				trg_d.c = -cor_s[COR_STG].x;
				trg_d.s = -cor_s[COR_STG].y;
			end
			default: begin
				trg_d.c = cor_s[COR_STG].y;
				trg_d.s = -cor_s[COR_STG].x;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[TRG_IDX]) begin
			trg_s <= trg_d;
		end
	end

	// Four independent products of a coordinate and a Q2.30 trig value.
	always_ff @(posedge clk) begin
		if (en[PRD_IDX]) begin
			prd_s.cmd  <= trg_s.cmd;
			prd_s.ox   <= trg_s.ox;
			prd_s.oy   <= trg_s.oy;
			prd_s.p_xc <= PROD_W'($signed(trg_s.ax) * $signed(trg_s.c));
			prd_s.p_ys <= PROD_W'($signed(trg_s.ay) * $signed(trg_s.s));
			prd_s.p_yc <= PROD_W'($signed(trg_s.ay) * $signed(trg_s.c));
			prd_s.p_xs <= PROD_W'($signed(trg_s.ax) * $signed(trg_s.s));
		end
	end

	// Combine the products and round half up to the coordinate format.
	logic signed [SUM_W-1:0] xc_w, ys_w, yc_w, xs_w, sum_x, sum_y;
	always_comb begin
		xc_w = SUM_W'(prd_s.p_xc);
		ys_w = SUM_W'(prd_s.p_ys);
		yc_w = SUM_W'(prd_s.p_yc);
		xs_w = SUM_W'(prd_s.p_xs);
		if (prd_s.cmd == CMD_W2L) begin
			sum_x = xc_w + ys_w + ROUND_HALF;
			sum_y = yc_w - xs_w + ROUND_HALF;
		end else begin
			sum_x = xc_w - ys_w + ROUND_HALF;
			sum_y = xs_w + yc_w + ROUND_HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (en[RND_IDX]) begin
			rnd_s.cmd <= prd_s.cmd;
			rnd_s.ox  <= prd_s.ox;
			rnd_s.oy  <= prd_s.oy;
			rnd_s.rx  <= sum_x[SUM_W-1:TRIG_FRAC];
			rnd_s.ry  <= sum_y[SUM_W-1:TRIG_FRAC];
		end
	end

	// Add the origin for local to world, then clamp to the coordinate range.
	function automatic logic signed [COORD_W-1:0] sat_coord(logic signed [FIN_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v[FIN_W-1:COORD_W-1] == '0 || v[FIN_W-1:COORD_W-1] == '1) begin
			r = v[COORD_W-1:0];
		end else if (v[FIN_W-1]) begin
			r = COORD_MIN;
		end else begin
			r = COORD_MAX;
		end
		return r;
	endfunction

	logic signed [FIN_W-1:0] fin_x, fin_y;
	always_comb begin
		fin_x = FIN_W'(rnd_s.rx);
		fin_y = FIN_W'(rnd_s.ry);
		if (rnd_s.cmd == CMD_L2W) begin
			fin_x = fin_x + FIN_W'(rnd_s.ox);
			fin_y = fin_y + FIN_W'(rnd_s.oy);
		end
	end

	always_ff @(posedge clk) begin
		if (en[RSP_IDX]) begin
			rsp_s.out_x <= sat_coord(fin_x);
			rsp_s.out_y <= sat_coord(fin_y);
		end
	end

endmodule

FILE: tb/sv/pft_checker.sv
// Response checker for the planar frame transform unit: predicts each request's result.
// Watches both channels, keeps the expected points in order and compares field by field.
// Depends on pft_pkg for the request and response payload types.
module pft_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  pft_pkg::pft_req_t req,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  pft_pkg::pft_rsp_t rsp,
	output int                mismatch_count,
	output int                pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import pft_pkg::*;

	localparam int     ROT_STAGES = 24;
	localparam int     ROT_FRAC   = 30;
	localparam longint ROT_GAIN   = 64'sd652032874;
	localparam longint COORD_HI   = 64'sd2147483647;
	localparam longint COORD_LO   = -64'sd2147483648;
	localparam int     PRINT_CAP  = 100;

	// Arctangent of 2^-i, in units of 2^-32 of a full turn.
	localparam longint ARC_STEP [ROT_STAGES] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	pft_rsp_t expected_points [$];
	int       rsp_seen;

	function automatic longint round_q30(input longint v);
		return (v + (64'sd1 <<< (ROT_FRAC - 1))) >>> ROT_FRAC;
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
		if (v > COORD_HI)
			return COORD_HI[COORD_W-1:0];
		if (v < COORD_LO)
			return COORD_LO[COORD_W-1:0];
		return v[COORD_W-1:0];
	endfunction

	function automatic pft_rsp_t transform_point(input pft_req_t r);
		logic [PHASE_BITS-1:0] phase;
		quad_t                 quad;
		longint                cx, cy, zz, xs, ys, cos_v, sin_v;
		longint                px, py, ox, oy, dx, dy, rx, ry;
		pft_rsp_t              o;
		phase = {r.angle, {(PHASE_BITS - ANGLE_BITS){1'b0}}};
		quad  = quad_t'(phase[PHASE_BITS-1 -: 2]);
		zz    = longint'({2'b00, phase[PHASE_BITS-3:0]});
		cx    = ROT_GAIN;
		cy    = 0;
		for (int i = 0; i < ROT_STAGES; i++) begin
			xs = cx >>> i;
			ys = cy >>> i;
			if (zz >= 0) begin
				cx = cx - ys;
				cy = cy + xs;
				zz = zz - ARC_STEP[i];
			end else begin
				cx = cx + ys;
				cy = cy - xs;
				zz = zz + ARC_STEP[i];
			end
		end
		case (quad)
			QUAD_I: begin
				cos_v = cx;
				sin_v = cy;
			end
			QUAD_II: begin
				cos_v = -cy;
				sin_v = cx;
			end
			QUAD_III: begin
				cos_v = -cx;
				sin_v = -cy;
			end
			default: begin
				cos_v = cy;
				sin_v = -cx;
			end
		endcase
		px = $signed(r.pos_x);
		py = $signed(r.pos_y);
		ox = $signed(r.origin_x);
		oy = $signed(r.origin_y);
		if (r.cmd == CMD_W2L) begin
			dx = px - ox;
			dy = py - oy;
			rx = round_q30(dx * cos_v + dy * sin_v);
			ry = round_q30(dy * cos_v - dx * sin_v);
		end else begin
			rx = round_q30(px * cos_v - py * sin_v) + ox;
			ry = round_q30(px * sin_v + py * cos_v) + oy;
		end
		o.out_x = clamp_coord(rx);
		o.out_y = clamp_coord(ry);
		return o;
	endfunction

	// Only the first lines are printed so that a broken design cannot flood the log.
	task automatic report_mismatch(input string what, input int idx,
			input logic signed [COORD_W-1:0] got, input logic signed [COORD_W-1:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("%0t pft_checker: response %0d %s: got %0d, expected %0d",
				$realtime, idx, what, got, want);
		mismatch_count++;
	endtask

	initial begin
		mismatch_count = 0;
		pending_count  = 0;
		rsp_seen       = 0;
	end

	always @(posedge clk) begin
		pft_rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_points.size() == 0) begin
					report_mismatch("arrived with nothing pending, out_x", rsp_seen,
						rsp.out_x, '0);
				end else begin
					want = expected_points.pop_front();
					if (rsp.out_x !== want.out_x)
						report_mismatch("out_x", rsp_seen, rsp.out_x, want.out_x);
					if (rsp.out_y !== want.out_y)
						report_mismatch("out_y", rsp_seen, rsp.out_y, want.out_y);
				end
				rsp_seen++;
			end
			if (req_valid && req_ready)
				expected_points.insert(expected_points.size(), transform_point(req));
			pending_count = expected_points.size();
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the planar frame transform testbench: clock, reset, request stimulus and verdict.
// Instantiates planar_frame_transform_unit and pft_checker; depends on pft_pkg.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pft_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_REQS  = 1950;
	// The pipe is 17 stages deep, so a generous drain covers any straggler.
	localparam int DRAIN_CYCLES = 40;
	// Longest honest silence is a receiver hold.
	localparam int IDLE_LIMIT   = 2000;

	localparam logic signed [COORD_W-1:0] CMAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] CMIN = 32'sh8000_0000;
	localparam logic signed [COORD_W-1:0] ONE  = 32'sh0001_0000;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_SPARSE,
		RX_HOLD
	} rx_mode_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     rsp_ready = 1'b0;
	pft_req_t req       = '0;
	logic     req_ready;
	logic     rsp_valid;
	pft_rsp_t rsp;
	int       mismatches;
	int       pending;
	int       burst_left = 0;

	planar_frame_transform_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	pft_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.rsp            (rsp),
		.mismatch_count (mismatches),
		.pending_count  (pending)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	function automatic pft_req_t make_req(input cmd_t c,
			input logic signed [COORD_W-1:0] px, input logic signed [COORD_W-1:0] py,
			input logic signed [COORD_W-1:0] ox, input logic signed [COORD_W-1:0] oy,
			input logic [ANGLE_BITS-1:0] a);
		pft_req_t r;
		r.cmd      = c;
		r.pos_x    = px;
		r.pos_y    = py;
		r.origin_x = ox;
		r.origin_y = oy;
		r.angle    = a;
		return r;
	endfunction

	// Coordinates mix full-range values with small ones near zero, values hugging the
	// saturation limits, exact zero and values of every magnitude, so that both the
	// ordinary rotation and the clamping paths get plenty of traffic.
	function automatic logic signed [COORD_W-1:0] rand_coord();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom;
			4, 5: v = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
			6: v = $urandom_range(0, 1) ? CMAX - int'($urandom_range(0, 255))
				: CMIN + int'($urandom_range(0, 255));
			7: v = 0;
			default: v = $signed($urandom) >>> $urandom_range(0, 31);
		endcase
		return v;
	endfunction

	// Angles are mostly uniform; the rest sit on or next to the quadrant boundaries
	// and at the very ends of the range, where the quadrant mapping takes over.
	function automatic logic [ANGLE_BITS-1:0] rand_angle();
		logic [ANGLE_BITS-1:0] a;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: a = 16'($urandom);
			6, 7: a = {2'($urandom_range(0, 3)), 14'b0} + 16'($urandom_range(0, 4)) - 16'd2;
			8: a = 16'($urandom_range(0, 15));
			default: a = 16'hFFFF - 16'($urandom_range(0, 15));
		endcase
		return a;
	endfunction

	// Offers one request and returns on the falling edge after it was taken. The sender
	// works in bursts; when a burst runs out, valid may drop for a random gap before
	// the next burst starts. Some bursts are long so that stretches without any gap
	// appear. Valid is only ever written once per falling edge.
	task automatic send_request(input pft_req_t r);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 40);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req       <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		@(negedge clk);
	endtask

	// Request stimulus and the verdict.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: identity, saturation in both directions and both commands,
		// the four quadrant boundaries and the angles right next to them.
		send_request(make_req(CMD_W2L, 0, 0, 0, 0, 16'h0000));
		send_request(make_req(CMD_W2L, CMAX, CMAX, CMIN, CMIN, 16'h0000));
		send_request(make_req(CMD_W2L, CMIN, CMIN, CMAX, CMAX, 16'h0000));
		send_request(make_req(CMD_W2L, CMAX, CMIN, CMIN, CMAX, 16'h8000));
		send_request(make_req(CMD_L2W, CMAX, CMAX, CMAX, CMAX, 16'h0000));
		send_request(make_req(CMD_L2W, CMIN, CMIN, CMIN, CMIN, 16'h0000));
		send_request(make_req(CMD_L2W, CMAX, 0, 0, 0, 16'h4000));
		send_request(make_req(CMD_L2W, CMIN, CMIN, 0, 0, 16'h2000));
		send_request(make_req(CMD_W2L, ONE, 0, 0, 0, 16'h4000));
		send_request(make_req(CMD_W2L, ONE, 2 * ONE, 0, 0, 16'hC000));
		send_request(make_req(CMD_L2W, ONE, 2 * ONE, 3 * ONE, -4 * ONE, 16'hFFFF));
		send_request(make_req(CMD_W2L, 5 * ONE, -7 * ONE, ONE, ONE, 16'h0001));
		send_request(make_req(CMD_L2W, -3 * ONE, 9 * ONE, -ONE, 2 * ONE, 16'h8000));
		send_request(make_req(CMD_W2L, 100 * ONE, 50 * ONE, 0, 0, 16'h7FFF));
		send_request(make_req(CMD_L2W, 100 * ONE, 50 * ONE, 0, 0, 16'h3FFF));
		send_request(make_req(CMD_W2L, -100 * ONE, 50 * ONE, 0, 0, 16'h4001));
		send_request(make_req(CMD_L2W, CMAX, CMIN, CMIN, CMAX, 16'hC000));
		send_request(make_req(CMD_W2L, -1, -1, 1, 1, 16'hBFFF));
		send_request(make_req(CMD_L2W, 32'sh0000_8000, -32'sh0000_8000, 0, 0, 16'h2000));
		send_request(make_req(CMD_W2L, CMAX, 0, CMIN, 0, 16'h2000));

		// Random part. Every request is a well-formed point, so every one exercises
		// the whole pipe; the coordinate and angle mixes do the rest.
		repeat (RANDOM_REQS) begin
			send_request(make_req(cmd_t'($urandom_range(0, 1)), rand_coord(), rand_coord(),
				rand_coord(), rand_coord(), rand_angle()));
		end
		req_valid <= 1'b0;

		// Let every outstanding response drain, then give the pipe time to show any
		// response that nobody asked for.
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// The receiver runs segments of different stall patterns. The first segments are
	// fixed: a short open stretch and then a long hold, so that the pipe fills behind a
	// stalled output and pushes back on the request side while requests keep coming.
	// Later holds come at random.
	initial begin
		rx_mode_t mode;
		int       seg_len;
		int       seg;
		int       pick;
		seg = 0;
		wait (arst_n);
		forever begin
			if (seg == 0) begin
				mode    = RX_OPEN;
				seg_len = 60;
			end else if (seg == 1) begin
				mode    = RX_HOLD;
				seg_len = 180;
			end else begin
				pick = $urandom_range(0, 15);
				if (pick == 0) begin
					mode    = RX_HOLD;
					seg_len = $urandom_range(60, 200);
				end else if (pick <= 5) begin
					mode    = RX_OPEN;
					seg_len = $urandom_range(20, 300);
				end else if (pick <= 11) begin
					mode    = RX_RANDOM;
					seg_len = $urandom_range(20, 300);
				end else begin
					mode    = RX_SPARSE;
					seg_len = $urandom_range(20, 100);
				end
			end
			seg++;
			repeat (seg_len) begin
				@(negedge clk);
				case (mode)
					RX_OPEN:   rsp_ready <= 1'b1;
					RX_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: rsp_ready <= ($urandom_range(0, 4) == 0);
					default:   rsp_ready <= 1'b0;
				endcase
			end
		end
	end

	// Watchdog: any accepted request or response counts as progress.
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle = 0;
			else
				idle++;
		end
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
src/pft_pkg.sv
src/planar_frame_transform_unit.sv
tb/sv/pft_checker.sv
tb/sv/tb_top.sv
